FILE: rtl/bsv_pkg.sv
// ----------------------------------------------------------------------------
// bsv_pkg
// Shared widths, constants, register codes and word types of the box sdf
// voxel sampler.
// ----------------------------------------------------------------------------
package bsv_pkg;

  // field widths
  localparam int COORD_W  = 32;
  localparam int HALF_W   = 31;
  localparam int CELL_W   = 31;
  localparam int IDX_W    = 8;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  // datapath widths
  localparam int PROD_W  = IDX_W + CELL_W;
  localparam int DIFF_W  = PROD_W + 3;
  localparam int GAP_W   = DIFF_W + 1;
  localparam int POS_W   = 31;
  localparam int SQ_W    = 2 * POS_W;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 4;
  localparam int TOT_W   = ROOT_W + 2;

  // pipeline shape
  localparam int FRONT_STAGES    = 4;
  localparam int SQRT_STAGES     = ROOT_W;
  localparam int QUEUE_DEPTH_DEF = 8;

  // constants
  localparam logic [CELL_W-1:0]         CELL_SIZE_RESET = CELL_W'(2621);
  localparam logic signed [COORD_W-1:0] FAR_DISTANCE    = COORD_W'(655360);
  localparam logic signed [COORD_W-1:0] DIST_MAX        = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] DIST_MIN        = {1'b1, {(COORD_W-1){1'b0}}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_HALF_X    = 3'd3,
    CFG_HALF_Y    = 3'd4,
    CFG_HALF_Z    = 3'd5,
    CFG_PRESENT   = 3'd6,
    CFG_CELL_SIZE = 3'd7
  } bsv_cfg_t;

  // box geometry as held in configuration
  typedef struct packed {
    logic [2:0][COORD_W-1:0] center;
    logic [2:0][HALF_W-1:0]  half;
    logic [CELL_W-1:0]       cell_size;
  } bsv_box_t;

  // classified word handed from front to back through the queue
  typedef struct packed {
    logic                      far;
    logic [2:0][POS_W-1:0]     pos;
    logic signed [COORD_W-1:0] inner;
    logic                      last;
  } bsv_item_t;

  // side data carried along the square root pipeline
  typedef struct packed {
    logic                      far;
    logic signed [COORD_W-1:0] inner;
    logic                      last;
  } bsv_tag_t;

endpackage

FILE: rtl/bsv_front.sv
// ----------------------------------------------------------------------------
// bsv_front
// Accepts voxel words, forms the sample point and the per-axis gap to the
// box, and classifies the word (far flag, positive parts, inside term).
// Admission is credit based on queue fill plus words in flight.
// ----------------------------------------------------------------------------
module bsv_front #(
  parameter int QUEUE_DEPTH = bsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      voxel_valid,
  output logic                                      voxel_ready,
  input  logic signed [bsv_pkg::COORD_W-1:0]        origin_x,
  input  logic signed [bsv_pkg::COORD_W-1:0]        origin_y,
  input  logic signed [bsv_pkg::COORD_W-1:0]        origin_z,
  input  logic [bsv_pkg::IDX_W-1:0]                 index_i,
  input  logic [bsv_pkg::IDX_W-1:0]                 index_j,
  input  logic [bsv_pkg::IDX_W-1:0]                 index_k,
  input  logic                                      last_voxel,
  input  bsv_pkg::bsv_box_t                         box,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]          q_count,
  output logic                                      push,
  output bsv_pkg::bsv_item_t                        item
);
  import bsv_pkg::*;

  localparam int OCC_W = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);

  logic                      accept;
  logic [OCC_W-1:0]          occupancy;
  logic signed [COORD_W-1:0] org_in [3];
  logic [IDX_W-1:0]          idx_in [3];

  // stage registers
  logic                      v1, v2, v3, v4;
  logic [PROD_W-1:0]         prod1 [3];
  logic signed [COORD_W-1:0] org1 [3];
  logic                      last1, last2, last3;
  logic signed [DIFF_W-1:0]  diff2 [3];
  logic signed [GAP_W-1:0]   gap3 [3];

  // classification logic
  logic [DIFF_W-1:0]         mag [3];
  logic signed [GAP_W-1:0]   top01, top;
  bsv_item_t                 item_next;

  assign org_in[0] = origin_x;
  assign org_in[1] = origin_y;
  assign org_in[2] = origin_z;
  assign idx_in[0] = index_i;
  assign idx_in[1] = index_j;
  assign idx_in[2] = index_k;

  // credit check: every word in flight has a queue slot waiting
  assign occupancy = OCC_W'(q_count) + OCC_W'(v1) + OCC_W'(v2) + OCC_W'(v3) + OCC_W'(v4);
  assign voxel_ready = occupancy < OCC_W'(QUEUE_DEPTH);
  assign accept = voxel_valid & voxel_ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // stage 1: index times cell size
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      prod1[a] <= PROD_W'(idx_in[a]) * PROD_W'(box.cell_size);
      org1[a]  <= org_in[a];
    end
    last1 <= last_voxel;
  end

  // stage 2: sample point minus center
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      diff2[a] <= DIFF_W'(org1[a]) + DIFF_W'(prod1[a]) - DIFF_W'(signed'(box.center[a]));
    end
    last2 <= last1;
  end

  // stage 3: magnitude minus half extent
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag[a] = diff2[a][DIFF_W-1] ? DIFF_W'(-diff2[a]) : DIFF_W'(diff2[a]);
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      gap3[a] <= GAP_W'(mag[a]) - GAP_W'(box.half[a]);
    end
    last3 <= last2;
  end

  // stage 4: classify, largest gap gives the inside term
  always_comb begin
    top01 = (gap3[0] > gap3[1]) ? gap3[0] : gap3[1];
    top   = (top01 > gap3[2]) ? top01 : gap3[2];
    item_next.far = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (!gap3[a][GAP_W-1] && (|gap3[a][GAP_W-2:POS_W])) begin
        item_next.far = 1'b1;
      end
      item_next.pos[a] = gap3[a][GAP_W-1] ? '0 : gap3[a][POS_W-1:0];
    end
    item_next.inner = top[GAP_W-1] ? signed'(top[COORD_W-1:0]) : '0;
    item_next.last  = last3;
  end

  always_ff @(posedge clk) begin
    item <= item_next;
  end

  assign push = v4;

endmodule

FILE: rtl/bsv_queue.sv
// ----------------------------------------------------------------------------
// bsv_queue
// Short first-in first-out queue of classified words between the front and
// the back; the head word is shown while the queue is not empty.
// ----------------------------------------------------------------------------
module bsv_queue #(
  parameter int QUEUE_DEPTH = bsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  bsv_pkg::bsv_item_t               push_item,
  input  logic                             pop,
  output logic                             head_valid,
  output bsv_pkg::bsv_item_t               head_item,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
  import bsv_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bsv_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic             do_pop;

  assign head_valid = count != '0;
  assign head_item  = slots[rptr];
  assign do_pop     = pop & head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(do_pop);
    end
  end

endmodule

FILE: rtl/bsv_sqrt.sv
// ----------------------------------------------------------------------------
// bsv_sqrt
// Pipelined integer square root, rounded down: one result bit per stage,
// restoring digit recurrence, with side data carried alongside.
// ----------------------------------------------------------------------------
module bsv_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bsv_pkg::SUM_W-1:0]   in_value,
  input  bsv_pkg::bsv_tag_t           in_tag,
  output logic                        out_valid,
  output logic [bsv_pkg::ROOT_W-1:0]  out_root,
  output bsv_pkg::bsv_tag_t           out_tag
);
  import bsv_pkg::*;

  logic [SQRT_STAGES-1:0] vld;
  logic [ROOT_W-1:0]      root [SQRT_STAGES];
  logic [REM_W-1:0]       rem  [SQRT_STAGES];
  logic [SUM_W-1:0]       rad  [SQRT_STAGES];
  bsv_tag_t               tag  [SQRT_STAGES];

  logic [ROOT_W-1:0]      root_src [SQRT_STAGES];
  logic [REM_W-1:0]       rem_src  [SQRT_STAGES];
  logic [SUM_W-1:0]       rad_src  [SQRT_STAGES];
  bsv_tag_t               tag_src  [SQRT_STAGES];
  logic [REM_W-1:0]       cand     [SQRT_STAGES];
  logic [REM_W-1:0]       trial    [SQRT_STAGES];

  // stage inputs: first stage from the port, others from the stage before
  always_comb begin
    root_src[0] = '0;
    rem_src[0]  = '0;
    rad_src[0]  = in_value;
    tag_src[0]  = in_tag;
    for (int s = 1; s < SQRT_STAGES; s++) begin
      root_src[s] = root[s-1];
      rem_src[s]  = rem[s-1];
      rad_src[s]  = rad[s-1];
      tag_src[s]  = tag[s-1];
    end
  end

  // bring down two radicand bits, try root*4+1
  always_comb begin
    for (int s = 0; s < SQRT_STAGES; s++) begin
      cand[s]  = {rem_src[s][REM_W-3:0], rad_src[s][SUM_W-1 -: 2]};
      trial[s] = REM_W'({root_src[s], 2'b01});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        if (cand[s] >= trial[s]) begin
          rem[s]  <= cand[s] - trial[s];
          root[s] <= {root_src[s][ROOT_W-2:0], 1'b1};
        end else begin
          rem[s]  <= cand[s];
          root[s] <= {root_src[s][ROOT_W-2:0], 1'b0};
        end
        rad[s] <= {rad_src[s][SUM_W-3:0], 2'b00};
        tag[s] <= tag_src[s];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQRT_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign out_root  = root[SQRT_STAGES-1];
  assign out_tag   = tag[SQRT_STAGES-1];

endmodule

FILE: rtl/bsv_back.sv
// ----------------------------------------------------------------------------
// bsv_back
// Takes classified words from the queue, squares and sums the positive
// parts, takes the square root and forms the saturated distance in the
// output register.
// ----------------------------------------------------------------------------
module bsv_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               box_present,
  input  logic                               head_valid,
  input  bsv_pkg::bsv_item_t                 head_item,
  output logic                               pop,
  output logic                               sample_valid,
  input  logic                               sample_ready,
  output logic signed [bsv_pkg::COORD_W-1:0] distance,
  output logic                               last_out
);
  import bsv_pkg::*;

  logic                      en;
  logic                      v1, v2;
  logic [SQ_W-1:0]           sq1 [3];
  bsv_tag_t                  tag1, tag2;
  logic [SUM_W-1:0]          sum2;
  logic                      root_valid;
  logic [ROOT_W-1:0]         root;
  bsv_tag_t                  root_tag;
  logic signed [TOT_W-1:0]   total;
  logic signed [COORD_W-1:0] total_sat;
  logic signed [COORD_W-1:0] dist_next;

  // whole back pipeline moves when the output register is free or taken
  assign en  = ~sample_valid | sample_ready;
  assign pop = en & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= head_valid;
      v2 <= v1;
    end
  end

  // squares of the positive parts
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        sq1[a] <= SQ_W'(head_item.pos[a]) * SQ_W'(head_item.pos[a]);
      end
      tag1.far   <= head_item.far;
      tag1.inner <= head_item.inner;
      tag1.last  <= head_item.last;
    end
  end

  // squared length
  always_ff @(posedge clk) begin
    if (en) begin
      sum2 <= SUM_W'(sq1[0]) + SUM_W'(sq1[1]) + SUM_W'(sq1[2]);
      tag2 <= tag1;
    end
  end

  bsv_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .in_value  (sum2),
    .in_tag    (tag2),
    .out_valid (root_valid),
    .out_root  (root),
    .out_tag   (root_tag)
  );

  // length plus inside term, saturated; no box or a far word overrides it
  always_comb begin
    total = TOT_W'(root) + TOT_W'(signed'(root_tag.inner));
    if (total[TOT_W-1:COORD_W-1] == '0 || total[TOT_W-1:COORD_W-1] == '1) begin
      total_sat = signed'(total[COORD_W-1:0]);
    end else begin
      total_sat = total[TOT_W-1] ? DIST_MIN : DIST_MAX;
    end
    priority if (!box_present) begin
      dist_next = FAR_DISTANCE;
    end else if (root_tag.far) begin
      dist_next = DIST_MAX;
    end else begin
      dist_next = total_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (en) begin
      sample_valid <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && root_valid) begin
      distance <= dist_next;
      last_out <= root_tag.last;
    end
  end

endmodule

FILE: rtl/box_sdf_voxel_sampler.sv
// ----------------------------------------------------------------------------
// box_sdf_voxel_sampler
// Signed distance from each voxel's sample point to one configured
// axis-aligned box, Q15.16 metres, saturated.
// ----------------------------------------------------------------------------
// path from voxel acceptance to sample_valid, in order:
//   4 front stages, queue, 2 square stages, 32 root stages, output register
// throughput: one voxel per cycle when not stalled, set by the root pipeline
// voxel_ready follows queue fill plus words in the front; the queue holds
//   QUEUE_DEPTH words, so a stalled output still takes that many voxels
// reset: synchronous, resets valid bits, queue pointers and configuration
module box_sdf_voxel_sampler #(
  parameter int QUEUE_DEPTH = bsv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bsv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsv_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                voxel_valid,
  output logic                                voxel_ready,
  input  logic signed [bsv_pkg::COORD_W-1:0]  origin_x,
  input  logic signed [bsv_pkg::COORD_W-1:0]  origin_y,
  input  logic signed [bsv_pkg::COORD_W-1:0]  origin_z,
  input  logic [bsv_pkg::IDX_W-1:0]           index_i,
  input  logic [bsv_pkg::IDX_W-1:0]           index_j,
  input  logic [bsv_pkg::IDX_W-1:0]           index_k,
  input  logic                                last_voxel,
  output logic                                sample_valid,
  input  logic                                sample_ready,
  output logic signed [bsv_pkg::COORD_W-1:0]  distance,
  output logic                                last_out
);
  import bsv_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  bsv_box_t          box;
  logic              box_present;
  logic              push;
  bsv_item_t         push_item;
  logic              pop;
  logic              head_valid;
  bsv_item_t         head_item;
  logic [CNT_W-1:0]  q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      box.center    <= '0;
      box.half      <= '0;
      box.cell_size <= CELL_SIZE_RESET;
      box_present   <= 1'b0;
    end else if (cfg_write) begin
      unique case (bsv_cfg_t'(cfg_index))
        CFG_CENTER_X:  box.center[0] <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Y:  box.center[1] <= cfg_data[COORD_W-1:0];
        CFG_CENTER_Z:  box.center[2] <= cfg_data[COORD_W-1:0];
        CFG_HALF_X:    box.half[0]   <= cfg_data[HALF_W-1:0];
        CFG_HALF_Y:    box.half[1]   <= cfg_data[HALF_W-1:0];
        CFG_HALF_Z:    box.half[2]   <= cfg_data[HALF_W-1:0];
        CFG_PRESENT:   box_present   <= cfg_data[0];
        CFG_CELL_SIZE: box.cell_size <= cfg_data[CELL_W-1:0];
        default:       box_present   <= box_present;
      endcase
    end
  end

  bsv_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .voxel_valid (voxel_valid),
    .voxel_ready (voxel_ready),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .origin_z    (origin_z),
    .index_i     (index_i),
    .index_j     (index_j),
    .index_k     (index_k),
    .last_voxel  (last_voxel),
    .box         (box),
    .q_count     (q_count),
    .push        (push),
    .item        (push_item)
  );

  bsv_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  bsv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .box_present  (box_present),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .distance     (distance),
    .last_out     (last_out)
  );

endmodule

FILE: rtl/bsv_checker.sv
// ----------------------------------------------------------------------------
// bsv_checker
// Port-level checks of the box sdf voxel sampler, bound to the top level.
// ----------------------------------------------------------------------------
module bsv_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cfg_write,
  input logic [bsv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [bsv_pkg::CFG_W-1:0]           cfg_data,
  input logic                                voxel_ready,
  input logic                                sample_valid,
  input logic                                sample_ready,
  input logic signed [bsv_pkg::COORD_W-1:0]  distance,
  input logic                                last_out
);
  import bsv_pkg::*;

  logic present_seen;

  // box present flag as written through the port
  always_ff @(posedge clk) begin
    if (rst) begin
      present_seen <= 1'b0;
    end else if (cfg_write && cfg_index == CFG_PRESENT) begin
      present_seen <= cfg_data[0];
    end
  end

  // a stalled word stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> sample_valid)
    else $error("sample word dropped while stalled");

  // a stalled word keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |=> $stable(distance) && $stable(last_out))
    else $error("sample payload changed while stalled");

  // empty after reset, so voxels are taken at once
  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> voxel_ready && !sample_valid)
    else $error("not empty and ready after reset");

  // with no box every sample reads the far distance
  a_no_box_far: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !present_seen |-> distance == FAR_DISTANCE)
    else $error("distance not far with no box present");

endmodule

bind box_sdf_voxel_sampler bsv_checker u_bsv_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for box_sdf_voxel_sampler. A short scripted run covers
// the absent box, the zero and extreme registers, far outside saturation and
// inside distances. Random phases with fresh box settings follow. Every
// returned sample is compared in order against a scripted answer or a local
// fixed-point model of the box distance. Both handshakes idle at random, and
// one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import bsv_pkg::*;

  localparam int        HOLD_CYCLES  = 300;
  localparam int        STALL_LIMIT  = 2000;
  localparam int        DRAIN_CYCLES = 60;
  localparam int        PHASES       = 8;
  localparam int        PHASE_ITEMS  = 88;
  localparam longint    ONE_M        = 65536;

  // one voxel word as offered to the block
  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] oz;
    logic [IDX_W-1:0]          i;
    logic [IDX_W-1:0]          j;
    logic [IDX_W-1:0]          k;
    logic                      last;
  } voxel_t;

  // one sample word as returned by the block
  typedef struct packed {
    logic signed [COORD_W-1:0] dist_val;
    logic                      last;
  } sample_t;

  typedef enum logic {ROW_VOXEL, ROW_WRITE} row_kind_t;

  // scripted row: a register write or a voxel, with an optional known answer
  typedef struct packed {
    row_kind_t                 kind;
    bsv_cfg_t                  sel;
    logic [CFG_W-1:0]          val;
    voxel_t                    vox;
    logic                      known;
    logic signed [COORD_W-1:0] want;
  } script_row_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  bsv_cfg_t                  cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      voxel_valid;
  logic                      voxel_ready;
  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic signed [COORD_W-1:0] origin_z;
  logic [IDX_W-1:0]          index_i;
  logic [IDX_W-1:0]          index_j;
  logic [IDX_W-1:0]          index_k;
  logic                      last_voxel;
  logic                      sample_valid;
  logic                      sample_ready;
  logic signed [COORD_W-1:0] distance;
  logic                      last_out;

  // local copy of the box registers
  longint ctr_pos [3];
  longint half_len [3];
  longint cell_len;
  bit     box_on;

  sample_t     dist_pending [$];
  script_row_t script_rows [$];
  int          mismatch_count;
  int          idle_cycles;
  bit          no_idle;
  bit          hold_output;

  box_sdf_voxel_sampler u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .voxel_valid  (voxel_valid),
    .voxel_ready  (voxel_ready),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .index_i      (index_i),
    .index_j      (index_j),
    .index_k      (index_k),
    .last_voxel   (last_voxel),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .distance     (distance),
    .last_out     (last_out)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor of the square root of a 64-bit value, one result bit at a time
  function automatic logic [31:0] floor_root64(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[31:0];
  endfunction

  // signed distance from the voxel sample point to the configured box
  function automatic logic signed [COORD_W-1:0] sdf_predict(input voxel_t v);
    longint      org [3];
    longint      idx [3];
    longint      gap [3];
    longint      diff;
    longint      top;
    longint      total;
    logic [63:0] sq_sum;
    if (!box_on) return FAR_DISTANCE;
    org[0] = longint'(v.ox);
    org[1] = longint'(v.oy);
    org[2] = longint'(v.oz);
    idx[0] = longint'(v.i);
    idx[1] = longint'(v.j);
    idx[2] = longint'(v.k);
    // per-axis gap outside the box faces, negative inside
    for (int a = 0; a < 3; a++) begin
      diff = org[a] + idx[a] * cell_len - ctr_pos[a];
      if (diff < 0) diff = -diff;
      gap[a] = diff - half_len[a];
    end
    top = gap[0];
    for (int a = 0; a < 3; a++) begin
      if (gap[a] > longint'(DIST_MAX)) return DIST_MAX;
      if (gap[a] > top) top = gap[a];
    end
    sq_sum = '0;
    for (int a = 0; a < 3; a++) begin
      if (gap[a] > 0) sq_sum += 64'(gap[a] * gap[a]);
    end
    total = longint'(floor_root64(sq_sum)) + ((top < 0) ? top : 0);
    if (total > longint'(DIST_MAX)) return DIST_MAX;
    if (total < longint'(DIST_MIN)) return DIST_MIN;
    return total[COORD_W-1:0];
  endfunction

  // register write, mirrored into the local box copy
  task automatic write_reg(input bsv_cfg_t sel, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (sel)
      CFG_CENTER_X:  ctr_pos[0] = longint'(signed'(data));
      CFG_CENTER_Y:  ctr_pos[1] = longint'(signed'(data));
      CFG_CENTER_Z:  ctr_pos[2] = longint'(signed'(data));
      CFG_HALF_X:    half_len[0] = longint'(data[HALF_W-1:0]);
      CFG_HALF_Y:    half_len[1] = longint'(data[HALF_W-1:0]);
      CFG_HALF_Z:    half_len[2] = longint'(data[HALF_W-1:0]);
      CFG_PRESENT:   box_on = data[0];
      CFG_CELL_SIZE: cell_len = longint'(data[CELL_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // offer one voxel after a gap and log its expected sample on acceptance
  task automatic send_voxel(input voxel_t v, input int gap, input logic known,
                            input logic signed [COORD_W-1:0] want);
    sample_t exp_word;
    if (gap > 0) begin
      voxel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    voxel_valid <= 1'b1;
    origin_x    <= v.ox;
    origin_y    <= v.oy;
    origin_z    <= v.oz;
    index_i     <= v.i;
    index_j     <= v.j;
    index_k     <= v.k;
    last_voxel  <= v.last;
    @(posedge clk);
    while (!voxel_ready) @(posedge clk);
    exp_word.dist_val = known ? want : sdf_predict(v);
    exp_word.last     = v.last;
    dist_pending.push_back(exp_word);
  endtask

  // stop offering and wait for every outstanding sample
  task automatic settle();
    voxel_valid <= 1'b0;
    while (dist_pending.size() != 0) @(posedge clk);
  endtask

  task automatic add_write(input bsv_cfg_t sel, input logic [CFG_W-1:0] val);
    script_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.sel   = sel;
    r.val   = val;
    script_rows.push_back(r);
  endtask

  task automatic add_voxel(input logic [31:0] ox, input logic [31:0] oy,
                           input logic [31:0] oz, input logic [7:0] i,
                           input logic [7:0] j, input logic [7:0] k,
                           input logic last, input logic known,
                           input logic [31:0] want);
    script_row_t r;
    r          = '0;
    r.kind     = ROW_VOXEL;
    r.vox.ox   = ox;
    r.vox.oy   = oy;
    r.vox.oz   = oz;
    r.vox.i    = i;
    r.vox.j    = j;
    r.vox.k    = k;
    r.vox.last = last;
    r.known    = known;
    r.want     = want;
    script_rows.push_back(r);
  endtask

  // random voxel: mostly a grid laid around the box centre, some raw noise
  function automatic voxel_t make_voxel();
    voxel_t v;
    longint org [3];
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 4) == 0)
        org[a] = longint'($urandom);
      else
        org[a] = ctr_pos[a] - 128 * cell_len
                 + longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    end
    v.ox   = org[0][COORD_W-1:0];
    v.oy   = org[1][COORD_W-1:0];
    v.oz   = org[2][COORD_W-1:0];
    v.i    = IDX_W'($urandom_range(0, 255));
    v.j    = IDX_W'($urandom_range(0, 255));
    v.k    = IDX_W'($urandom_range(0, 255));
    v.last = ($urandom_range(0, 7) == 0);
    return v;
  endfunction

  // box settings for one random phase, every register written
  task automatic load_box(input int phase);
    logic [CFG_W-1:0] pick [8];
    case (phase)
      0: begin
        // all extremes high
        pick = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF};
      end
      1: begin
        // lowest centre, point box, smallest cell
        pick = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001};
      end
      2: begin
        // box absent, geometry junk
        for (int r = 0; r < 8; r++) pick[r] = $urandom;
        pick[CFG_PRESENT] = {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0};
      end
      3: begin
        // fully random words, box present
        for (int r = 0; r < 8; r++) pick[r] = $urandom;
        pick[CFG_PRESENT][0] = 1'b1;
      end
      default: begin
        // realistic scene, upper bit of the unsigned registers as junk
        for (int r = 0; r < 3; r++)
          pick[r] = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
        for (int r = 3; r < 6; r++)
          pick[r] = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1 << 20))};
        pick[CFG_PRESENT]   = {31'($urandom), 1'b1};
        pick[CFG_CELL_SIZE] = {1'($urandom_range(0, 1)),
                               31'($urandom_range(1, 1 << 16))};
      end
    endcase
    for (int r = 0; r < 8; r++) write_reg(bsv_cfg_t'(r), pick[r]);
  endtask

  // output side: random stalls, one long hold on request, in-order checking
  initial begin
    sample_t want;
    int      gap;
    sample_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        sample_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        sample_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      sample_ready <= 1'b1;
      @(posedge clk);
      while (!sample_valid) @(posedge clk);
      if (dist_pending.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected sample word: distance %0d last %0b", distance, last_out);
      end else begin
        want = dist_pending.pop_front();
        if (distance !== want.dist_val || last_out !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("sample mismatch: distance exp %0d got %0d, last exp %0b got %0b",
                     want.dist_val, distance, want.last, last_out);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((voxel_valid && voxel_ready) || (sample_valid && sample_ready) || cfg_write)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // stimulus
  initial begin
    script_row_t r;
    rst            <= 1'b1;
    cfg_write      <= 1'b0;
    cfg_index      <= CFG_CENTER_X;
    cfg_data       <= '0;
    voxel_valid    <= 1'b0;
    origin_x       <= '0;
    origin_y       <= '0;
    origin_z       <= '0;
    index_i        <= '0;
    index_j        <= '0;
    index_k        <= '0;
    last_voxel     <= 1'b0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    hold_output    = 1'b0;
    for (int a = 0; a < 3; a++) begin
      ctr_pos[a]  = 0;
      half_len[a] = 0;
    end
    cell_len = longint'(CELL_SIZE_RESET);
    box_on   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // no box after reset: far distance whatever the voxel
    add_voxel(32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, FAR_DISTANCE);
    add_voxel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd255, 8'd255, 8'd255,
              1'b1, 1'b1, FAR_DISTANCE);
    add_voxel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd255, 8'd128,
              1'b0, 1'b1, FAR_DISTANCE);
    // point box at the origin
    add_write(CFG_PRESENT, 32'h1);
    add_voxel(32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'h0);
    add_voxel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, 8'd0,
              1'b1, 1'b1, DIST_MAX);
    add_voxel(32'(ONE_M), 32'h0, 32'h0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 32'(ONE_M));
    add_voxel(32'(3 * ONE_M), 32'(4 * ONE_M), 32'h0, 8'd0, 8'd0, 8'd0,
              1'b0, 1'b1, 32'(5 * ONE_M));
    // unit half extents: inside distances
    add_write(CFG_HALF_X, 32'(ONE_M));
    add_write(CFG_HALF_Y, 32'(ONE_M));
    add_write(CFG_HALF_Z, 32'(ONE_M));
    add_voxel(32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, -32'(ONE_M));
    add_voxel(-32'(ONE_M / 2), 32'h0, 32'h0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1,
              -32'(ONE_M / 2));
    // zero cell size samples the origin for every index
    add_write(CFG_CELL_SIZE, 32'h0);
    add_voxel(32'h0, 32'h0, 32'h0, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, -32'(ONE_M));
    // largest cell size
    add_write(CFG_CELL_SIZE, 32'h7FFF_FFFF);
    add_voxel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd255, 8'd255, 8'd255,
              1'b0, 1'b0, 32'h0);
    add_voxel(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd1, 8'd1, 8'd1,
              1'b0, 1'b0, 32'h0);
    // extreme centres, half extent with the unused top bit set
    add_write(CFG_CENTER_X, 32'h8000_0000);
    add_write(CFG_CENTER_Y, 32'h7FFF_FFFF);
    add_write(CFG_CENTER_Z, 32'h1234_5678);
    add_write(CFG_HALF_X, 32'hFFFF_FFFF);
    add_voxel(32'h7FFF_FFFF, 32'h0, 32'h0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 32'h0);
    add_voxel(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 8'd0, 8'd0, 8'd0,
              1'b1, 1'b0, 32'h0);
    add_voxel(32'h8000_0000, 32'h7FFF_0000, 32'h1230_0000, 8'd0, 8'd0, 8'd3,
              1'b0, 1'b0, 32'h0);
    // smallest cell, box switched off by bit 0 only
    add_write(CFG_CELL_SIZE, 32'h1);
    add_write(CFG_PRESENT, 32'hFFFF_FFFE);
    add_voxel(32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 8'd170, 8'd85, 8'd15,
              1'b1, 1'b1, FAR_DISTANCE);
    add_write(CFG_PRESENT, 32'h1);
    add_voxel(32'h8000_0000, 32'h7FFF_FF00, 32'h1234_0000, 8'd255, 8'd200, 8'd100,
              1'b0, 1'b0, 32'h0);

    // walk the script
    for (int n = 0; n < script_rows.size(); n++) begin
      r = script_rows[n];
      if (r.kind == ROW_WRITE) begin
        settle();
        write_reg(r.sel, r.val);
      end else begin
        send_voxel(r.vox, $urandom_range(0, 9), r.known, r.want);
      end
    end

    // random phases
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      load_box(phase);
      no_idle     = (phase == 4 || phase == 5);
      hold_output = (phase == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender pause until the block is empty
        if (phase == 6 && n == PHASE_ITEMS / 2) settle();
        send_voxel(make_voxel(), no_idle ? 0 : $urandom_range(0, 9), 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
